@@ design/sdsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsm_pkg: shared definitions for the scanline DMA slot map
// Line timing constants, per-mode fetch shape tables and the types that
// carry a decoded row shape from the decoder to the slot logic.
// ----------------------------------------------------------------------------
package sdsm_pkg;

    localparam int LINE_CYCLES   = 114;
    // Width that holds any line length in range plus one.
    localparam int CW            = 9;

    localparam int REFRESH_START = 25;
    localparam int REFRESH_LAST  = 57;
    localparam int NORMAL_LEFT   = 21;
    localparam int WIDTH_SHIFT   = 8;
    localparam int WIDE_PHASE    = 2;
    localparam int HBLANK_START  = 106;
    localparam int SCROLL_BIT    = 4;

    localparam int LEFT_NARROW   = NORMAL_LEFT + WIDTH_SHIFT;
    localparam int LEFT_WIDE     = NORMAL_LEFT + WIDE_PHASE - WIDTH_SHIFT;

    localparam logic [1:0] W_NARROW = 2'd0;
    localparam logic [1:0] W_NORMAL = 2'd1;
    localparam logic [1:0] W_WIDE   = 2'd2;

    localparam logic [2:0] ROW_NONE = 3'd5;

    typedef enum logic [2:0] {
        K_NONE,
        K_BITMAP,
        K_DENSE,
        K_FIRST,
        K_SPARSE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        first;
        logic [1:0]  stride_log;
        logic [4:0]  nom;
        logic [4:0]  start;
        logic [5:0]  chars;
        logic [5:0]  names;
    } t_shape;

    typedef struct packed {
        logic [3:0] stride_lead;
        logic [3:0] stride_later;
        logic [5:0] bytes_narrow;
        logic [5:0] bytes_normal;
    } t_row;

    function automatic logic [2:0] mode_row(input logic [3:0] mode);
        logic [2:0] row;
        case (mode)
            4'd2, 4'd3, 4'd4, 4'd5: row = 3'd0;
            4'd6, 4'd7:             row = 3'd1;
            4'd8, 4'd9:             row = 3'd2;
            4'd10, 4'd11, 4'd12:    row = 3'd3;
            4'd13, 4'd14, 4'd15:    row = 3'd4;
            default:                row = ROW_NONE;
        endcase
        return row;
    endfunction

    function automatic t_row shape_row(input logic [2:0] row);
        t_row s;
        case (row)
            3'd0:    s = '{4'd1, 4'd2, 6'd32, 6'd40};
            3'd1:    s = '{4'd2, 4'd4, 6'd16, 6'd20};
            3'd2:    s = '{4'd8, 4'd0, 6'd8,  6'd10};
            3'd3:    s = '{4'd4, 4'd0, 6'd16, 6'd20};
            3'd4:    s = '{4'd2, 4'd0, 6'd32, 6'd40};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] stride_log(input logic [3:0] stride);
        logic [1:0] l;
        case (stride)
            4'd2:    l = 2'd1;
            4'd4:    l = 2'd2;
            4'd8:    l = 2'd3;
            default: l = 2'd0;
        endcase
        return l;
    endfunction

endpackage

@@ design/sdsm_decode.sv @@
// ----------------------------------------------------------------------------
// sdsm_decode: row shape decoder
// Turns mode, width, first-line flag and scroll into the fetch kind, stride,
// first fetch cycle and byte counts of the row.
// ----------------------------------------------------------------------------
module sdsm_decode import sdsm_pkg::*; (
    input  logic [4:0] i_mode_byte,
    input  logic [1:0] i_window_width,
    input  logic       i_first_line,
    input  logic [3:0] i_hscrol,
    output t_shape     o_shape
);

    logic       scrolled;
    logic [3:0] mode;
    logic [1:0] win;
    logic [1:0] w;
    logic [2:0] row;
    t_row       s;
    logic [3:0] stride;
    logic [4:0] base;
    logic [4:0] nom;
    logic [5:0] extra;
    logic [5:0] chars_base;
    logic [5:0] names_base;

    always_comb begin
        scrolled = i_mode_byte[SCROLL_BIT] || (i_hscrol != 4'd0);
        mode     = i_mode_byte[3:0];
        win      = (i_window_width > W_WIDE) ? W_WIDE : i_window_width;
        // A scrolled row widens by one step; a wide row stays wide.
        w        = (scrolled && win != W_WIDE) ? win + 2'd1 : win;
        row      = mode_row(mode);
        s        = shape_row(row);
        stride   = i_first_line ? s.stride_lead : s.stride_later;

        case (w)
            W_NARROW: base = 5'(LEFT_NARROW);
            W_NORMAL: base = 5'(NORMAL_LEFT);
            default:  base = 5'(LEFT_WIDE);
        endcase
        nom = base - {2'b00, i_hscrol[3:1]};

        // A scrolled wide row fetches a quarter of the narrow count more.
        extra      = (scrolled && win == W_WIDE) ? {2'b00, s.bytes_narrow[5:2]} : 6'd0;
        chars_base = (w == W_NARROW) ? s.bytes_narrow : s.bytes_normal;
        names_base = (w == W_WIDE) ? s.bytes_narrow + {1'b0, s.bytes_narrow[5:1]}
                                   : chars_base;

        o_shape.first      = i_first_line;
        o_shape.stride_log = stride_log(stride);
        o_shape.nom        = nom;
        o_shape.chars      = chars_base + extra;
        o_shape.names      = names_base + extra;

        if (mode[3]) begin
            o_shape.start = nom - 5'd1;
        end else if (i_first_line) begin
            o_shape.start = nom - 5'd3;
        end else begin
            o_shape.start = nom;
        end

        if (row == ROW_NONE || stride == 4'd0) begin
            o_shape.kind = K_NONE;
        end else if (mode[3]) begin
            o_shape.kind = K_BITMAP;
        end else if (stride == 4'd1) begin
            o_shape.kind = K_DENSE;
        end else if (i_first_line) begin
            o_shape.kind = K_FIRST;
        end else begin
            o_shape.kind = K_SPARSE;
        end
    end

endmodule

@@ design/sdsm_slot.sv @@
// ----------------------------------------------------------------------------
// sdsm_slot: per-cycle slot decision
// Given a decoded row shape and a cycle index, decides whether the cycle is
// taken and which line-buffer byte it fetches.
// ----------------------------------------------------------------------------
module sdsm_slot import sdsm_pkg::*; (
    input  t_shape     i_shape,
    input  logic [6:0] i_cycle,
    output logic       o_blocked,
    output logic       o_name_valid,
    output logic [6:0] o_name_index
);

    function automatic logic on_refresh(input logic [6:0] c);
        return (c >= 7'(REFRESH_START)) && (c <= 7'(REFRESH_LAST))
            && (c[1:0] == 2'(REFRESH_START));
    endfunction

    // True when a fetch of the sequence base, base+stride, ... lands on p.
    function automatic logic fetch_at(input logic [6:0] p, input logic [6:0] base,
                                      input logic [1:0] ls, input logic [6:0] count);
        logic [6:0] d;
        logic [6:0] mask;
        d    = p - base;
        mask = ~(7'h7F << ls);
        return (p >= base) && ((d & mask) == 7'd0) && ((d >> ls) < count);
    endfunction

    logic [6:0] x;
    logic       in_line;
    logic [6:0] start7;
    logic [6:0] nom7;
    logic [6:0] chars7;
    logic [6:0] names7;
    logic [6:0] d_s;
    logic [6:0] d_n;
    logic [6:0] mask;
    logic [6:0] idx_s;
    logic [6:0] q;
    logic [6:0] q1;
    logic [1:0] r;
    logic [7:0] dense_lim;

    always_comb begin
        x         = i_cycle;
        in_line   = {2'b00, x} < CW'(LINE_CYCLES);
        start7    = {2'b00, i_shape.start};
        nom7      = {2'b00, i_shape.nom};
        chars7    = {1'b0, i_shape.chars};
        names7    = {1'b0, i_shape.names};
        d_s       = x - start7;
        d_n       = x - nom7;
        mask      = ~(7'h7F << i_shape.stride_log);
        idx_s     = d_s >> i_shape.stride_log;
        q         = {2'b00, d_n[6:2]};
        q1        = q + 7'd1;
        r         = d_n[1:0];
        dense_lim = {1'b0, i_shape.chars, 1'b0} + 8'd2;

        o_blocked    = on_refresh(x)
                    || (i_shape.first && (x == 7'd1 || x == 7'd6 || x == 7'd7));
        o_name_valid = 1'b0;
        o_name_index = 7'd0;

        case (i_shape.kind)
            K_BITMAP: begin
                if ((x >= start7) && ((d_s & mask) == 7'd0) && (idx_s < chars7)) begin
                    // Fetches in horizontal blank still count but are not taken.
                    if (x < 7'(HBLANK_START)) begin
                        o_blocked = 1'b1;
                    end
                    if (idx_s < names7) begin
                        o_name_valid = 1'b1;
                        o_name_index = idx_s;
                    end
                end
            end
            K_DENSE: begin
                if (x == start7) begin
                    o_blocked    = 1'b1;
                    o_name_valid = 1'b1;
                end else if ((x >= start7) && (d_s >= 7'd2) && ({1'b0, d_s} < dense_lim)) begin
                    o_blocked = 1'b1;
                    // Every other cycle after the lead-in is a name fetch.
                    if (d_s[0] && ((d_s >> 1) < names7)) begin
                        o_name_valid = 1'b1;
                        o_name_index = d_s >> 1;
                    end
                end
            end
            K_FIRST: begin
                // Fetches come in pairs at the head of each group of cycles, the pair
                // slipping later when its slot is a refresh; the last group has only its first cycle.
                if (x == start7) begin
                    o_blocked    = 1'b1;
                    o_name_valid = 1'b1;
                end else if (x >= nom7) begin
                    case (r)
                        2'd0: begin
                            if (!on_refresh(x) && (q < chars7)) begin
                                o_blocked = 1'b1;
                            end
                        end
                        2'd1: begin
                            if (on_refresh(x - 7'd1)) begin
                                if (q < chars7) begin
                                    o_blocked = 1'b1;
                                end
                            end else if (q1 < chars7) begin
                                o_blocked = 1'b1;
                                if (q1 < names7) begin
                                    o_name_valid = 1'b1;
                                    o_name_index = q1;
                                end
                            end
                        end
                        2'd2: begin
                            if (on_refresh(x - 7'd2) && (q1 < chars7)) begin
                                o_blocked = 1'b1;
                                if (q1 < names7) begin
                                    o_name_valid = 1'b1;
                                    o_name_index = q1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            K_SPARSE: begin
                if ((!on_refresh(x) && fetch_at(x, nom7, i_shape.stride_log, chars7))
                    || ((x != 7'd0) && on_refresh(x - 7'd1)
                        && fetch_at(x - 7'd1, nom7, i_shape.stride_log, chars7))) begin
                    o_blocked = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (!in_line) begin
            o_blocked    = 1'b0;
            o_name_valid = 1'b0;
            o_name_index = 7'd0;
        end
    end

endmodule

@@ design/scanline_dma_slot_map.sv @@
// ----------------------------------------------------------------------------
// scanline_dma_slot_map: DMA slot map for one machine cycle of a scanline
// Decides whether a cycle is stolen for DMA and which line-buffer byte it
// fetches, from the display mode, playfield width, first-line flag and scroll.
//
// Usage: present mode, width, first-line flag, scroll and cycle index with
// start high; the item is taken at any rising edge with start high, and busy
// is always low, so a new cycle index can be issued on every clock.
// The item is registered at acceptance, the slot decision is computed from
// that register in one pass of logic, and the result lands in the output
// register at the next clock. o_strobe marks the single cycle in which
// cycle_blocked, name_valid and name_index hold the result; the receiver
// must take it then. Throughput is one item per clock.
// name_index reads zero whenever name_valid is low, and a cycle index at or
// beyond the line length gives all-zero results.
// Reset (synchronous, active low) drops any item in flight; no strobe follows
// an item that was accepted before reset.
// ----------------------------------------------------------------------------
module scanline_dma_slot_map import sdsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] i_mode_byte,
    input  logic [1:0] i_window_width,
    input  logic       i_first_line,
    input  logic [3:0] i_hscrol,
    input  logic [6:0] i_cycle,
    output logic       o_strobe,
    output logic       o_cycle_blocked,
    output logic       o_name_valid,
    output logic [6:0] o_name_index
);

    logic       r_vld;
    logic [4:0] r_mode_byte;
    logic [1:0] r_window_width;
    logic       r_first_line;
    logic [3:0] r_hscrol;
    logic [6:0] r_cycle;

    logic       r_strobe;
    logic       r_blocked;
    logic       r_name_valid;
    logic [6:0] r_name_index;

    t_shape     shape;
    logic       n_blocked;
    logic       n_name_valid;
    logic [6:0] n_name_index;

    assign busy = 1'b0;

    sdsm_decode u_decode (
        .i_mode_byte    (r_mode_byte),
        .i_window_width (r_window_width),
        .i_first_line   (r_first_line),
        .i_hscrol       (r_hscrol),
        .o_shape        (shape)
    );

    sdsm_slot u_slot (
        .i_shape      (shape),
        .i_cycle      (r_cycle),
        .o_blocked    (n_blocked),
        .o_name_valid (n_name_valid),
        .o_name_index (n_name_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= start && !busy;
            r_strobe <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode_byte    <= i_mode_byte;
            r_window_width <= i_window_width;
            r_first_line   <= i_first_line;
            r_hscrol       <= i_hscrol;
            r_cycle        <= i_cycle;
        end
        if (r_vld) begin
            r_blocked    <= n_blocked;
            r_name_valid <= n_name_valid;
            r_name_index <= n_name_index;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_cycle_blocked = r_blocked;
    assign o_name_valid    = r_name_valid;
    assign o_name_index    = r_name_index;

    // Every accepted transfer is followed by a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("result strobe missing two cycles after acceptance");

    // A name fetch that is not stolen can only be in horizontal blank.
    a_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && n_name_valid && !n_blocked) |-> (r_cycle >= 7'(HBLANK_START)))
        else $error("unstolen name fetch before horizontal blank");

    // The index field is cleared when no byte is fetched.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_name_valid) |-> (o_name_index == 7'd0))
        else $error("name index not zero without a fetch");

    // Cycles past the end of the line give empty results.
    a_past_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && ({2'b00, r_cycle} >= CW'(LINE_CYCLES))) |=> (!o_cycle_blocked && !o_name_valid))
        else $error("result beyond the line is not empty");

endmodule
